### sv/dctd_pkg.sv
`default_nettype none
package dctd_pkg;
    localparam int PRIME_LIMIT = 65536;
    localparam int PRIME_COUNT = 6542;
    localparam int MW = $clog2(PRIME_LIMIT);
    localparam int PW = $clog2(PRIME_COUNT + 1);
    localparam int AW = $clog2(PRIME_COUNT);
    localparam int CW = 11;
    localparam int XW = 16;

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_SIV_R = 11'b00000000010,
        S_SIV_T = 11'b00000000100,
        S_MARK  = 11'b00000001000,
        S_COL_R = 11'b00000010000,
        S_COL_T = 11'b00000100000,
        S_IDLE  = 11'b00001000000,
        S_FETCH = 11'b00010000000,
        S_TEST  = 11'b00100000000,
        S_DIV   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;
endpackage
`default_nettype wire

### sv/divisor_count_trial_division_core.sv
// divisor counter by trial division over a stored prime table
// input: s_axis (tdata = value_in, 32 bits); output: m_axis (tdata = divisor_count, 11 bits
// in the low bits of 16)
// after reset the core clears a 65536-entry mark memory (one entry a cycle), sieves it,
// and collects the primes into a 6542-entry prime memory; s_axis_tready is low
// throughout this setup
// one value is processed at a time: each stored prime is fetched and compared, then
// tested with a restoring remainder per trial division (one for each division that
// succeeds plus the one that fails); the walk stops once prime * prime exceeds the rest
// or the prime table is exhausted
// the result sits in an output register; the core waits there until m_axis_tready is high,
// then takes the next transaction
`default_nettype none
module divisor_count_trial_division_core
    import dctd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // value_in[31:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // divisor_count[10:0], zero fill
);
    t_state r_st;
    logic [MW:0] r_i, r_j;
    logic [PW-1:0] r_cnt, r_k;
    logic mark_mem [PRIME_LIMIT];
    logic [XW-1:0] prime_mem [PRIME_COUNT];
    logic r_mrd;
    logic [XW-1:0] r_prd;
    logic [MW-1:0] mk_addr;
    logic mk_we, mk_wd;
    logic [31:0] r_rest, r_quo, r_rem;
    logic [5:0] r_bit;
    logic [XW-1:0] r_p;
    logic [4:0] r_e;
    logic [15:0] r_prod;
    logic [CW-1:0] r_res;
    logic [32:0] trial;
    logic [31:0] rem_sh;
    logic [31:0] psq;

    always_comb begin
        mk_we = 1'b0;
        mk_wd = 1'b0;
        mk_addr = r_i[MW-1:0];
        if (r_st == S_CLR) begin
            mk_we = 1'b1;
        end else if (r_st == S_MARK) begin
            mk_we = 1'b1;
            mk_wd = 1'b1;
            mk_addr = r_j[MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mk_we) mark_mem[mk_addr] <= mk_wd;
        r_mrd <= mark_mem[mk_addr];
        if (r_st == S_COL_T && !r_mrd && r_cnt < PW'(PRIME_COUNT))
            prime_mem[r_cnt[AW-1:0]] <= r_i[XW-1:0];
        r_prd <= prime_mem[r_k[AW-1:0]];
    end

    assign psq = 32'(r_prd) * 32'(r_prd);
    assign rem_sh = {r_rem[30:0], r_rest[5'(r_bit - 6'd1)]};
    assign trial = {1'b0, rem_sh} - {17'd0, r_p};

    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = (r_st == S_OUT);
    assign m_axis_tdata = {5'd0, r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_i <= '0;
            r_cnt <= '0;
            r_k <= '0;
        end else begin
            unique case (r_st)
                S_CLR: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == (MW+1)'(PRIME_LIMIT - 1)) begin
                        r_i <= (MW+1)'(2);
                        r_st <= S_SIV_R;
                    end
                end
                S_SIV_R: begin
                    if (r_i * r_i >= (2*MW+2)'(PRIME_LIMIT)) begin
                        r_i <= (MW+1)'(2);
                        r_st <= S_COL_R;
                    end else begin
                        r_st <= S_SIV_T;
                    end
                end
                S_SIV_T: begin
                    if (r_mrd) begin
                        r_i <= r_i + 1'b1;
                        r_st <= S_SIV_R;
                    end else begin
                        r_j <= (MW+1)'(r_i * r_i);
                        r_st <= S_MARK;
                    end
                end
                S_MARK: begin
                    if (r_j + r_i >= (MW+1)'(PRIME_LIMIT)) begin
                        r_i <= r_i + 1'b1;
                        r_st <= S_SIV_R;
                    end
                    r_j <= r_j + r_i;
                end
                S_COL_R: begin
                    if (r_i >= (MW+1)'(PRIME_LIMIT)) r_st <= S_IDLE;
                    else r_st <= S_COL_T;
                end
                S_COL_T: begin
                    if (!r_mrd && r_cnt < PW'(PRIME_COUNT)) r_cnt <= r_cnt + 1'b1;
                    r_i <= r_i + 1'b1;
                    r_st <= S_COL_R;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_rest <= s_axis_tdata;
                        r_prod <= 16'd1;
                        r_k <= '0;
                        if (s_axis_tdata == 32'd0) begin
                            r_res <= '0;
                            r_st <= S_OUT;
                        end else begin
                            r_st <= S_FETCH;
                        end
                    end
                end
                S_FETCH: r_st <= S_TEST;
                S_TEST: begin
                    if (r_k >= r_cnt || psq > r_rest) begin
                        r_res <= (r_rest > 32'd1) ? r_prod[CW-2:0] << 1 : r_prod[CW-1:0];
                        r_st <= S_OUT;
                    end else begin
                        r_p <= r_prd;
                        r_e <= '0;
                        r_rem <= '0;
                        r_bit <= 6'd32;
                        r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (!trial[32]) begin
                        r_rem <= trial[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == 6'd1) begin
                        if (trial[32] ? (rem_sh == 32'd0) : (trial[31:0] == 32'd0)) begin
                            r_rest <= {r_quo[30:0], ~trial[32]};
                            r_e <= r_e + 5'd1;
                            r_rem <= '0;
                            r_bit <= 6'd32;
                        end else begin
                            // exponent plus one can reach 32, so widen before adding
                            r_prod <= 16'(r_prod * ({11'd0, r_e} + 16'd1));
                            r_k <= r_k + 1'b1;
                            r_st <= S_FETCH;
                        end
                    end
                end
                S_OUT: if (m_axis_tready) r_st <= S_IDLE;
                default: r_st <= S_CLR;
            endcase
        end
    end
endmodule
`default_nettype wire
